// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that is also checked across reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/abg_pkg.sv -----
// Package: shared constants, types and a saturation helper for the anchor box generator
`default_nettype none
package abg_pkg;

    localparam int MAX_ANCHORS_DEF = 16;
    localparam int FRAC_BITS       = 16;
    localparam int GRID_BITS       = 12;

    localparam int GRID_W  = 12;
    localparam int SCALE_W = 27;
    localparam int COORD_W = 32;
    localparam int SLOT_W  = 4;
    localparam int CNT_W   = 5;
    localparam int SUM_W   = 48;

    // Size cap in fixed point and in whole pixels
    localparam logic [63:0] SIZE_CAP     = 64'd1 << 52;
    localparam logic [63:0] SIZE_CAP_INT = SIZE_CAP >> FRAC_BITS;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_ROUNDED = 3'd0,
        REG_PIXEL   = 3'd1,
        REG_CLIP    = 3'd2,
        REG_STRIDE  = 3'd3,
        REG_IMG_H   = 3'd4,
        REG_IMG_W   = 3'd5,
        REG_COUNT   = 3'd6
    } cfg_reg_t;

    // Command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EMIT = 1'b1;

    // One stored base box
    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic signed [COORD_W-1:0] right;
        logic signed [COORD_W-1:0] bottom;
    } box_t;

    // Saturate a wide signed value to 32 bits
    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (v > hi) begin
            sat32 = 32'sh7FFFFFFF;
        end else if (v < lo) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = v[COORD_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

// ----- src/abg_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle
`default_nettype none
module abg_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] num,
    input  wire logic [63:0] den,
    output logic             done,
    output logic [63:0]      quo,
    output logic [63:0]      rem
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] quo_reg, quo_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] den_reg, den_next;
    logic [64:0] shifted;

    // One shift-subtract step per cycle
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        shifted   = {rem_reg, quo_reg[63]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
        end else if (busy_reg) begin
            if (shifted >= {1'b0, den_reg}) begin
                rem_next = 64'(shifted - {1'b0, den_reg});
                quo_next = {quo_reg[62:0], 1'b1};
            end else begin
                rem_next = shifted[63:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule
`default_nettype wire

// ----- src/abg_sqrt.sv -----
// Integer square root, two radicand bits per cycle
`default_nettype none
module abg_sqrt (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] val,
    output logic             done,
    output logic [31:0]      root
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [63:0] v_reg, v_next;
    logic [63:0] r_reg, r_next;
    logic [63:0] b_reg, b_next;
    logic [63:0] trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        v_next    = v_reg;
        r_next    = r_reg;
        b_next    = b_reg;
        trial     = r_reg + b_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            v_next    = val;
            r_next    = '0;
            b_next    = 64'd1 << 62;
        end else if (busy_reg) begin
            if (v_reg >= trial) begin
                v_next = v_reg - trial;
                r_next = (r_reg >> 1) + b_reg;
            end else begin
                r_next = r_reg >> 1;
            end
            b_next   = b_reg >> 2;
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        v_reg   <= v_next;
        r_reg   <= r_next;
        b_reg   <= b_next;
    end

    assign done = done_reg;
    assign root = r_reg[31:0];

endmodule
`default_nettype wire

// ----- src/abg_table.sv -----
// Base anchor table: one write port, one registered read port
`default_nettype none
module abg_table #(
    parameter int DEPTH = abg_pkg::MAX_ANCHORS_DEF,
    parameter int AW    = 4
) (
    input  wire logic           aclk,
    input  wire logic           we,
    input  wire logic [AW-1:0]  waddr,
    input  wire abg_pkg::box_t  wdata,
    input  wire logic [AW-1:0]  raddr,
    output abg_pkg::box_t       rdata
);

    abg_pkg::box_t mem [DEPTH];
    abg_pkg::box_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ----- src/anchor_box_generator_top.sv -----
// Anchor box generator: load sequencer, emit sequencer, shared arithmetic units
// Load: float or rounded-ratio size formula, then pixel or normalized placement;
//   the sequencer waits on each division and each square root until it is done.
// Emit: cell shift setup (pixel, or normalized with two divisions), then one box per
//   table entry, each read only after the previous box is taken. s_tready is low meanwhile.
// Reset (aresetn, synchronous, active low) clears control and configuration;
//   table entries are undefined until loaded.
`default_nettype none
module anchor_box_generator_top #(
    parameter int MAX_ANCHORS = abg_pkg::MAX_ANCHORS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // Configuration write port
    input  wire logic         cfg_wr_en,
    input  wire logic [2:0]   cfg_addr,
    input  wire logic [26:0]  cfg_wdata,
    // Requests
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // tdata: anchor_index[3:0], box_scale[30:4], aspect_ratio[57:31],
    //        grid_x[69:58], grid_y[81:70], zero pad
    input  wire logic [87:0]  s_tdata,
    // tuser: cmd[0]
    input  wire logic [0:0]   s_tuser,
    // Results
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // tdata: box_x1[31:0], box_y1[63:32], box_x2[95:64], box_y2[127:96],
    //        box_slot[131:128], zero pad
    output logic [135:0]      m_tdata,
    output logic              m_tlast
);

    localparam int SLOTS = (MAX_ANCHORS < 16) ? MAX_ANCHORS : 16;
    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int F     = abg_pkg::FRAC_BITS;
    localparam logic [abg_pkg::GRID_W-1:0] GMASK =
        abg_pkg::GRID_W'((64'd1 << abg_pkg::GRID_BITS) - 64'd1);

    typedef enum logic [29:0] {
        ST_IDLE    = 30'd1 << 0,
        ST_F_SQRT  = 30'd1 << 1,
        ST_F_WDIV  = 30'd1 << 2,
        ST_F_HMUL  = 30'd1 << 3,
        ST_F_HGET  = 30'd1 << 4,
        ST_R_TT    = 30'd1 << 5,
        ST_R_TTGET = 30'd1 << 6,
        ST_R_QDIV  = 30'd1 << 7,
        ST_R_MSQ   = 30'd1 << 8,
        ST_R_MM    = 30'd1 << 9,
        ST_R_NSET  = 30'd1 << 10,
        ST_R_NR    = 30'd1 << 11,
        ST_R_HH    = 30'd1 << 12,
        ST_R_RATE  = 30'd1 << 13,
        ST_R_W     = 30'd1 << 14,
        ST_R_WGET  = 30'd1 << 15,
        ST_R_H     = 30'd1 << 16,
        ST_R_HGET  = 30'd1 << 17,
        ST_PLACE   = 30'd1 << 18,
        ST_P_DIV   = 30'd1 << 19,
        ST_WRITE   = 30'd1 << 20,
        ST_E_MX    = 30'd1 << 21,
        ST_E_SX    = 30'd1 << 22,
        ST_E_DX    = 30'd1 << 23,
        ST_E_MY    = 30'd1 << 24,
        ST_E_SY    = 30'd1 << 25,
        ST_E_DY    = 30'd1 << 26,
        ST_E_RD    = 30'd1 << 27,
        ST_E_OUT   = 30'd1 << 28,
        ST_E_WAIT  = 30'd1 << 29
    } state_t;

    // Configuration registers
    logic        rounded_reg, pixel_reg, clip_reg;
    logic [26:0] stride_reg;
    logic [15:0] img_h_reg, img_w_reg;
    logic [4:0]  count_reg;

    // Sequencer registers
    state_t      state_reg, state_next;
    logic        pend_reg, pend_next;
    logic [3:0]  slot_reg, slot_next;
    logic [26:0] s_reg, s_next;
    logic [26:0] r_reg, r_next;
    logic [31:0] sr_reg, sr_next;
    logic [52:0] w_reg, w_next;
    logic [52:0] h_reg, h_next;
    logic [63:0] num_reg, num_next;
    logic [63:0] quo_reg, quo_next;
    logic        remz_reg, remz_next;
    logic [31:0] m_reg, m_next;
    logic [31:0] n_reg, n_next;
    logic [31:0] hh_reg, hh_next;
    logic [31:0] rate_reg, rate_next;
    logic [1:0]  pi_reg, pi_next;
    logic signed [31:0] pl_reg [4];
    logic signed [31:0] pl_next [4];
    logic signed [abg_pkg::SUM_W-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic [4:0]  k_reg, k_next, cnt_reg, cnt_next;
    logic [11:0] gx_reg, gx_next, gy_reg, gy_next;
    logic [63:0] mul_reg;

    // Output register
    logic        mvalid_reg, mvalid_next;
    logic        olast_reg, olast_next;
    logic [3:0]  oslot_reg, oslot_next;
    logic signed [31:0] ox1_reg, ox1_next, oy1_reg, oy1_next;
    logic signed [31:0] ox2_reg, ox2_next, oy2_reg, oy2_next;

    // Shared units
    logic        div_start, div_done, sq_start, sq_done;
    logic [63:0] div_num, div_den, div_quo, div_rem, sq_val;
    logic [31:0] sq_root, mul_a, mul_b;
    logic        is_div, is_sq;

    // Table ports
    logic          tab_we;
    abg_pkg::box_t tab_wdata, tab_rdata;

    // Derived values
    logic [15:0] iw_eff, ih_eff;
    logic signed [63:0] tq, wq, hq;
    logic signed [63:0] pn [4];
    logic [63:0] pd [4];
    logic        pneg;
    logic signed [63:0] pq;
    logic [31:0] n0;
    logic        tie;
    logic [63:0] p_hh;
    logic [15:0] p_rem;
    logic signed [abg_pkg::SUM_W-1:0] hx, hy;
    logic signed [abg_pkg::SUM_W-1:0] v [4];
    logic [4:0]  cnt_lim;
    logic        in_acc;

    assign iw_eff = (img_w_reg == 16'd0) ? 16'd1 : img_w_reg;
    assign ih_eff = (img_h_reg == 16'd0) ? 16'd1 : img_h_reg;
    assign tq     = signed'(64'(stride_reg));
    assign wq     = signed'(64'(w_reg));
    assign hq     = signed'(64'(h_reg));
    assign in_acc = s_tvalid && s_tready;
    assign cnt_lim = (count_reg > 5'(SLOTS)) ? 5'(SLOTS) : count_reg;

    // Placement numerators and denominators, normalized form
    always_comb begin
        pn[0] = tq - wq;
        pn[1] = tq - hq;
        pn[2] = tq + wq;
        pn[3] = tq + hq;
        pd[0] = 64'(iw_eff) << 1;
        pd[1] = 64'(ih_eff) << 1;
        pd[2] = 64'(iw_eff) << 1;
        pd[3] = 64'(ih_eff) << 1;
    end
    assign pneg = pn[pi_reg][63];
    assign pq   = pneg ? signed'(~div_quo) : signed'(div_quo);

    // Clip bounds
    assign hx = pixel_reg ? signed'(abg_pkg::SUM_W'(iw_eff - 16'd1) << F)
                          : signed'(abg_pkg::SUM_W'(1) << F);
    assign hy = pixel_reg ? signed'(abg_pkg::SUM_W'(ih_eff - 16'd1) << F)
                          : signed'(abg_pkg::SUM_W'(1) << F);

    // Shifted emitted box, clipped when clipping is enabled
    always_comb begin
        v[0] = abg_pkg::SUM_W'(tab_rdata.left) + sx_reg;
        v[1] = abg_pkg::SUM_W'(tab_rdata.top) + sy_reg;
        v[2] = abg_pkg::SUM_W'(tab_rdata.right) + sx_reg;
        v[3] = abg_pkg::SUM_W'(tab_rdata.bottom) + sy_reg;
        if (clip_reg) begin
            for (int j = 0; j < 4; j++) begin
                if (v[j] > (j[0] ? hy : hx)) begin
                    v[j] = j[0] ? hy : hx;
                end
                if (v[j] < 0) begin
                    v[j] = '0;
                end
            end
        end
    end

    // Unit operand selection
    always_comb begin
        is_div  = 1'b0;
        is_sq   = 1'b0;
        div_num = '0;
        div_den = 64'd1;
        sq_val  = '0;
        mul_a   = '0;
        mul_b   = '0;
        unique case (state_reg)
            ST_F_SQRT: begin
                is_sq  = 1'b1;
                sq_val = 64'(r_reg) << F;
            end
            ST_F_WDIV: begin
                is_div  = 1'b1;
                div_num = 64'(s_reg) << F;
                div_den = 64'(sr_reg);
            end
            ST_F_HMUL: begin
                mul_a = 32'(s_reg);
                mul_b = sr_reg;
            end
            ST_R_TT: begin
                mul_a = 32'(stride_reg);
                mul_b = 32'(stride_reg);
            end
            ST_R_QDIV: begin
                is_div  = 1'b1;
                div_num = num_reg;
                div_den = 64'(r_reg) << F;
            end
            ST_R_MSQ: begin
                is_sq  = 1'b1;
                sq_val = quo_reg;
            end
            ST_R_MM: begin
                mul_a = m_reg;
                mul_b = m_reg;
            end
            ST_R_NR: begin
                mul_a = n_reg;
                mul_b = 32'(r_reg);
            end
            ST_R_RATE: begin
                is_div  = 1'b1;
                div_num = 64'(s_reg);
                div_den = 64'(stride_reg);
            end
            ST_R_W: begin
                mul_a = n_reg;
                mul_b = rate_reg;
            end
            ST_R_H: begin
                mul_a = hh_reg;
                mul_b = rate_reg;
            end
            ST_P_DIV: begin
                is_div  = 1'b1;
                div_num = pneg ? ~pn[pi_reg] : pn[pi_reg];
                div_den = pd[pi_reg];
            end
            ST_E_MX: begin
                mul_a = 32'(gx_reg);
                mul_b = 32'(stride_reg);
            end
            ST_E_DX: begin
                is_div  = 1'b1;
                div_num = 64'(sx_reg);
                div_den = 64'(iw_eff);
            end
            ST_E_MY: begin
                mul_a = 32'(gy_reg);
                mul_b = 32'(stride_reg);
            end
            ST_E_DY: begin
                is_div  = 1'b1;
                div_num = 64'(sy_reg);
                div_den = 64'(ih_eff);
            end
            default: begin
            end
        endcase
    end

    assign div_start = is_div && !pend_reg;
    assign sq_start  = is_sq && !pend_reg;

    // Rounding helpers for the rounded-ratio formula
    assign n0    = m_reg >> 1;
    assign tie   = remz_reg && (quo_reg == mul_reg);
    assign p_hh  = mul_reg >> F;
    assign p_rem = mul_reg[F-1:0];

    // Sequencer
    always_comb begin
        state_next  = state_reg;
        pend_next   = pend_reg;
        slot_next   = slot_reg;
        s_next      = s_reg;
        r_next      = r_reg;
        sr_next     = sr_reg;
        w_next      = w_reg;
        h_next      = h_reg;
        num_next    = num_reg;
        quo_next    = quo_reg;
        remz_next   = remz_reg;
        m_next      = m_reg;
        n_next      = n_reg;
        hh_next     = hh_reg;
        rate_next   = rate_reg;
        pi_next     = pi_reg;
        pl_next     = pl_reg;
        sx_next     = sx_reg;
        sy_next     = sy_reg;
        k_next      = k_reg;
        cnt_next    = cnt_reg;
        gx_next     = gx_reg;
        gy_next     = gy_reg;
        mvalid_next = mvalid_reg;
        olast_next  = olast_reg;
        oslot_next  = oslot_reg;
        ox1_next    = ox1_reg;
        oy1_next    = oy1_reg;
        ox2_next    = ox2_reg;
        oy2_next    = oy2_reg;
        tab_we      = 1'b0;

        if (div_start || sq_start) begin
            pend_next = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    slot_next = s_tdata[3:0];
                    s_next    = s_tdata[30:4];
                    r_next    = (s_tdata[57:31] == 27'd0) ? 27'd1 : s_tdata[57:31];
                    gx_next   = s_tdata[69:58] & GMASK;
                    gy_next   = s_tdata[81:70] & GMASK;
                    cnt_next  = cnt_lim;
                    k_next    = '0;
                    if (s_tuser[0] == abg_pkg::CMD_EMIT) begin
                        state_next = ST_E_MX;
                    end else if (5'(s_tdata[3:0]) >= 5'(SLOTS)) begin
                        state_next = ST_IDLE;
                    end else if (!rounded_reg) begin
                        state_next = ST_F_SQRT;
                    end else if (stride_reg == 27'd0) begin
                        w_next     = '0;
                        h_next     = '0;
                        state_next = ST_PLACE;
                    end else begin
                        state_next = ST_R_TT;
                    end
                end
            end
            // Float size formula
            ST_F_SQRT: begin
                if (sq_done) begin
                    pend_next  = 1'b0;
                    sr_next    = sq_root;
                    state_next = ST_F_WDIV;
                end
            end
            ST_F_WDIV: begin
                if (div_done) begin
                    pend_next  = 1'b0;
                    w_next     = (div_quo > abg_pkg::SIZE_CAP) ? 53'(abg_pkg::SIZE_CAP)
                                                               : 53'(div_quo);
                    state_next = ST_F_HMUL;
                end
            end
            ST_F_HMUL: state_next = ST_F_HGET;
            ST_F_HGET: begin
                h_next     = ((mul_reg >> F) > abg_pkg::SIZE_CAP)
                             ? 53'(abg_pkg::SIZE_CAP) : 53'(mul_reg >> F);
                state_next = ST_PLACE;
            end
            // Rounded-ratio size formula
            ST_R_TT: state_next = ST_R_TTGET;
            ST_R_TTGET: begin
                num_next   = mul_reg << 2;
                state_next = ST_R_QDIV;
            end
            ST_R_QDIV: begin
                if (div_done) begin
                    pend_next  = 1'b0;
                    quo_next   = div_quo;
                    remz_next  = (div_rem == 64'd0);
                    state_next = ST_R_MSQ;
                end
            end
            ST_R_MSQ: begin
                if (sq_done) begin
                    pend_next  = 1'b0;
                    m_next     = sq_root;
                    state_next = ST_R_MM;
                end
            end
            ST_R_MM: state_next = ST_R_NSET;
            ST_R_NSET: begin
                // round half to even of the width count
                n_next = n0;
                if (m_reg[0] && (!tie || n0[0])) begin
                    n_next = n0 + 32'd1;
                end
                state_next = ST_R_NR;
            end
            ST_R_NR: state_next = ST_R_HH;
            ST_R_HH: begin
                hh_next = 32'(p_hh);
                if ((p_rem > 16'h8000) || ((p_rem == 16'h8000) && p_hh[0])) begin
                    hh_next = 32'(p_hh) + 32'd1;
                end
                state_next = ST_R_RATE;
            end
            ST_R_RATE: begin
                if (div_done) begin
                    pend_next  = 1'b0;
                    rate_next  = 32'(div_quo);
                    state_next = ST_R_W;
                end
            end
            ST_R_W: state_next = ST_R_WGET;
            ST_R_WGET: begin
                w_next     = (mul_reg > abg_pkg::SIZE_CAP_INT)
                             ? 53'(abg_pkg::SIZE_CAP_INT << F) : 53'(mul_reg << F);
                state_next = ST_R_H;
            end
            ST_R_H: state_next = ST_R_HGET;
            ST_R_HGET: begin
                h_next     = (mul_reg > abg_pkg::SIZE_CAP_INT)
                             ? 53'(abg_pkg::SIZE_CAP_INT << F) : 53'(mul_reg << F);
                state_next = ST_PLACE;
            end
            // Placement
            ST_PLACE: begin
                if (pixel_reg) begin
                    pl_next[0] = abg_pkg::sat32((tq - wq) >>> 1);
                    pl_next[1] = abg_pkg::sat32((tq - hq) >>> 1);
                    pl_next[2] = abg_pkg::sat32((tq + wq - (64'sd2 <<< F)) >>> 1);
                    pl_next[3] = abg_pkg::sat32((tq + hq - (64'sd2 <<< F)) >>> 1);
                    state_next = ST_WRITE;
                end else begin
                    pi_next    = '0;
                    state_next = ST_P_DIV;
                end
            end
            ST_P_DIV: begin
                if (div_done) begin
                    pend_next       = 1'b0;
                    pl_next[pi_reg] = abg_pkg::sat32(pq);
                    pi_next         = pi_reg + 2'd1;
                    if (pi_reg == 2'd3) begin
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_WRITE: begin
                tab_we     = 1'b1;
                state_next = ST_IDLE;
            end
            // Emit: cell shift
            ST_E_MX: state_next = ST_E_SX;
            ST_E_SX: begin
                sx_next    = signed'(mul_reg[abg_pkg::SUM_W-1:0]);
                state_next = pixel_reg ? ST_E_MY : ST_E_DX;
            end
            ST_E_DX: begin
                if (div_done) begin
                    pend_next  = 1'b0;
                    sx_next    = signed'(div_quo[abg_pkg::SUM_W-1:0]);
                    state_next = ST_E_MY;
                end
            end
            ST_E_MY: state_next = ST_E_SY;
            ST_E_SY: begin
                sy_next = signed'(mul_reg[abg_pkg::SUM_W-1:0]);
                if (!pixel_reg) begin
                    state_next = ST_E_DY;
                end else begin
                    state_next = (cnt_reg == 5'd0) ? ST_IDLE : ST_E_RD;
                end
            end
            ST_E_DY: begin
                if (div_done) begin
                    pend_next  = 1'b0;
                    sy_next    = signed'(div_quo[abg_pkg::SUM_W-1:0]);
                    state_next = (cnt_reg == 5'd0) ? ST_IDLE : ST_E_RD;
                end
            end
            // Emit: one box per table entry
            ST_E_RD: state_next = ST_E_OUT;
            ST_E_OUT: begin
                ox1_next    = abg_pkg::sat32(64'(v[0]));
                oy1_next    = abg_pkg::sat32(64'(v[1]));
                ox2_next    = abg_pkg::sat32(64'(v[2]));
                oy2_next    = abg_pkg::sat32(64'(v[3]));
                oslot_next  = k_reg[3:0];
                olast_next  = (k_reg + 5'd1 == cnt_reg);
                mvalid_next = 1'b1;
                state_next  = ST_E_WAIT;
            end
            ST_E_WAIT: begin
                if (m_tready) begin
                    mvalid_next = 1'b0;
                    k_next      = k_reg + 5'd1;
                    state_next  = olast_reg ? ST_IDLE : ST_E_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pend_reg    <= 1'b0;
            mvalid_reg  <= 1'b0;
            rounded_reg <= 1'b0;
            pixel_reg   <= 1'b0;
            clip_reg    <= 1'b0;
            stride_reg  <= 27'd1048576;
            img_h_reg   <= 16'd1;
            img_w_reg   <= 16'd1;
            count_reg   <= 5'd1;
        end else begin
            state_reg  <= state_next;
            pend_reg   <= pend_next;
            mvalid_reg <= mvalid_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    abg_pkg::REG_ROUNDED: rounded_reg <= cfg_wdata[0];
                    abg_pkg::REG_PIXEL:   pixel_reg   <= cfg_wdata[0];
                    abg_pkg::REG_CLIP:    clip_reg    <= cfg_wdata[0];
                    abg_pkg::REG_STRIDE:  stride_reg  <= cfg_wdata;
                    abg_pkg::REG_IMG_H:   img_h_reg   <= cfg_wdata[15:0];
                    abg_pkg::REG_IMG_W:   img_w_reg   <= cfg_wdata[15:0];
                    abg_pkg::REG_COUNT:   count_reg   <= cfg_wdata[4:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        slot_reg  <= slot_next;
        s_reg     <= s_next;
        r_reg     <= r_next;
        sr_reg    <= sr_next;
        w_reg     <= w_next;
        h_reg     <= h_next;
        num_reg   <= num_next;
        quo_reg   <= quo_next;
        remz_reg  <= remz_next;
        m_reg     <= m_next;
        n_reg     <= n_next;
        hh_reg    <= hh_next;
        rate_reg  <= rate_next;
        pi_reg    <= pi_next;
        pl_reg    <= pl_next;
        sx_reg    <= sx_next;
        sy_reg    <= sy_next;
        k_reg     <= k_next;
        cnt_reg   <= cnt_next;
        gx_reg    <= gx_next;
        gy_reg    <= gy_next;
        olast_reg <= olast_next;
        oslot_reg <= oslot_next;
        ox1_reg   <= ox1_next;
        oy1_reg   <= oy1_next;
        ox2_reg   <= ox2_next;
        oy2_reg   <= oy2_next;
        mul_reg   <= 64'(mul_a) * 64'(mul_b);
    end

    assign tab_wdata.left   = pl_reg[0];
    assign tab_wdata.top    = pl_reg[1];
    assign tab_wdata.right  = pl_reg[2];
    assign tab_wdata.bottom = pl_reg[3];

    abg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo),
        .rem     (div_rem)
    );

    abg_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .val     (sq_val),
        .done    (sq_done),
        .root    (sq_root)
    );

    abg_table #(
        .DEPTH (SLOTS),
        .AW    (AW)
    ) u_table (
        .aclk  (aclk),
        .we    (tab_we),
        .waddr (slot_reg[AW-1:0]),
        .wdata (tab_wdata),
        .raddr (k_reg[AW-1:0]),
        .rdata (tab_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {4'd0, oslot_reg, oy2_reg, ox2_reg, oy1_reg, ox1_reg};

endmodule
`default_nettype wire

// ----- src/abg_checker.sv -----
// Port-level checker for the anchor box generator, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module abg_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic         m_tlast,
    input wire logic [135:0] m_tdata
);

    // A pending box holds until taken
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // No new request is taken while a box is pending
    `ASSERT_IMPL(a_busy, aclk, aresetn, m_tvalid, !s_tready)
    // After a box that is not the last, more boxes follow before the next request
    `ASSERT_NEXT(a_more, aclk, aresetn, m_tvalid && m_tready && !m_tlast, !s_tready)
    // Reset leaves no result pending
    `ASSERT_NEXT_ALWAYS(a_reset, aclk, !aresetn, !m_tvalid)

endmodule

bind anchor_box_generator_top abg_checker u_abg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .m_tdata  (m_tdata)
);
`default_nettype wire

// ----- test/tb.sv -----
// Self-checking stream testbench for the anchor box generator top level
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // One input request and one expected box
    typedef struct {
        logic        cmd;
        logic [3:0]  slot;
        logic [26:0] scale;
        logic [26:0] ratio;
        logic [11:0] gx;
        logic [11:0] gy;
    } req_t;

    typedef struct {
        logic [31:0] x1, y1, x2, y2;
        logic [3:0]  slot;
        logic        last;
    } box_exp_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_wr_en;
    logic [2:0]   cfg_addr;
    logic [26:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [87:0]  s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;
    logic         m_tlast;

    anchor_box_generator_top i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    // Clock
    always begin
        aclk = 1'b1; #5;
        aclk = 1'b0; #5;
    end

    // Predictor state: configuration copy and base box table
    bit          rounded_q, pixel_q, clip_q;
    bit [63:0]   stride_q, img_h_q, img_w_q, count_q;
    logic [31:0] tbl_left [16], tbl_top [16], tbl_right [16], tbl_bottom [16];

    req_t     pending_reqs[$];
    box_exp_t expected_boxes[$];
    int       errors = 0;
    int       cycle = 0;
    int       boxes_seen = 0;
    int       stuck = 0;

    function automatic bit [63:0] int_sqrt(bit [63:0] v);
        bit [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint fdiv(longint n, longint d);
        longint q;
        q = n / d;
        if (n % d != 0 && n < 0) q--;
        return q;
    endfunction

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic bit [63:0] mul_capped(bit [63:0] a, bit [63:0] b, bit [63:0] lim);
        if (a != 0 && b > lim / a) return lim;
        return (a * b > lim) ? lim : a * b;
    endfunction

    // Compute one base box into the table
    function automatic void load_base(int slot, bit [63:0] s, bit [63:0] r);
        bit [63:0] w, h, sr, den, num, quo, m, n, p, hh, rem, rate, cap, half;
        longint tq, wq, hq, iw, ih, one;
        bit tie;
        cap = 64'd1 << 52;
        half = 64'd1 << 15;
        one = 64'sd65536;
        if (r == 0) r = 1;
        if (!rounded_q) begin
            sr = int_sqrt(r << 16);
            w = (s << 16) / sr;
            h = (s * sr) >> 16;
            if (w > cap) w = cap;
            if (h > cap) h = cap;
        end else if (stride_q == 0) begin
            w = 0;
            h = 0;
        end else begin
            den = r << 16;
            num = 4 * stride_q * stride_q;
            quo = num / den;
            m = int_sqrt(quo);
            n = m >> 1;
            if (m[0]) begin
                tie = (num % den == 0) && (quo == m * m);
                if (!tie || n[0]) n++;
            end
            p = n * r;
            hh = p >> 16;
            rem = p & 64'hFFFF;
            if (rem > half || (rem == half && hh[0])) hh++;
            rate = s / stride_q;
            w = mul_capped(n, rate, cap >> 16) << 16;
            h = mul_capped(hh, rate, cap >> 16) << 16;
        end
        tq = longint'(stride_q);
        wq = longint'(w);
        hq = longint'(h);
        iw = (img_w_q != 0) ? longint'(img_w_q) : 1;
        ih = (img_h_q != 0) ? longint'(img_h_q) : 1;
        if (!pixel_q) begin
            tbl_left[slot]   = clamp32(fdiv(tq - wq, 2 * iw));
            tbl_top[slot]    = clamp32(fdiv(tq - hq, 2 * ih));
            tbl_right[slot]  = clamp32(fdiv(tq + wq, 2 * iw));
            tbl_bottom[slot] = clamp32(fdiv(tq + hq, 2 * ih));
        end else begin
            tbl_left[slot]   = clamp32(fdiv(tq - wq, 2));
            tbl_top[slot]    = clamp32(fdiv(tq - hq, 2));
            tbl_right[slot]  = clamp32(fdiv(tq + wq - 2 * one, 2));
            tbl_bottom[slot] = clamp32(fdiv(tq + hq - 2 * one, 2));
        end
    endfunction

    function automatic longint clip_to(longint v, longint hi);
        if (v > hi) v = hi;
        if (v < 0) v = 0;
        return v;
    endfunction

    // Queue the boxes one grid cell produces
    function automatic void predict_cell(bit [11:0] gxb, bit [11:0] gyb);
        longint gx, gy, t, iw, ih, sx, sy, hx, hy, v0, v1, v2, v3;
        int cnt;
        box_exp_t e;
        gx = gxb;
        gy = gyb;
        t = longint'(stride_q);
        iw = (img_w_q != 0) ? longint'(img_w_q) : 1;
        ih = (img_h_q != 0) ? longint'(img_h_q) : 1;
        if (!pixel_q) begin
            sx = fdiv(gx * t, iw);
            sy = fdiv(gy * t, ih);
            hx = 65536;
            hy = 65536;
        end else begin
            sx = gx * t;
            sy = gy * t;
            hx = (iw - 1) * 65536;
            hy = (ih - 1) * 65536;
        end
        cnt = (count_q > 16) ? 16 : int'(count_q);
        for (int k = 0; k < cnt; k++) begin
            v0 = longint'(signed'(tbl_left[k])) + sx;
            v1 = longint'(signed'(tbl_top[k])) + sy;
            v2 = longint'(signed'(tbl_right[k])) + sx;
            v3 = longint'(signed'(tbl_bottom[k])) + sy;
            if (clip_q) begin
                v0 = clip_to(v0, hx);
                v1 = clip_to(v1, hy);
                v2 = clip_to(v2, hx);
                v3 = clip_to(v3, hy);
            end
            e.x1 = clamp32(v0);
            e.y1 = clamp32(v1);
            e.x2 = clamp32(v2);
            e.y2 = clamp32(v3);
            e.slot = k[3:0];
            e.last = (k + 1 == cnt);
            expected_boxes.push_back(e);
        end
    endfunction

    // Request driver: new values at the falling edge, acceptance seen at the rising edge
    bit req_taken = 0;
    always @(posedge aclk) begin
        cycle <= cycle + 1;
        req_taken = s_tvalid && s_tready;
        if (req_taken) begin
            if (s_tuser[0] == abg_pkg::CMD_LOAD)
                load_base(int'(s_tdata[3:0]), 64'(s_tdata[30:4]), 64'(s_tdata[57:31]));
            else
                predict_cell(s_tdata[69:58], s_tdata[81:70]);
        end
    end

    function automatic bit idle_now();
        if (cycle >= 4000 && cycle < 9000) return 0;
        return $urandom_range(0, 99) < 20;
    endfunction

    always @(negedge aclk) begin
        req_t r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || req_taken) begin
            if (pending_reqs.size() != 0 && !idle_now()) begin
                r = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= r.cmd;
                s_tdata  <= {6'd0, r.gy, r.gx, r.ratio, r.scale, r.slot};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver, with one long hold-off once results are flowing
    int hold_left = 0;
    bit held = 0;
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!held && boxes_seen >= 60) begin
            held = 1;
            hold_left = 400;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !idle_now();
        end
    end

    // Result checker
    always @(posedge aclk) begin
        box_exp_t e;
        if (aresetn && m_tvalid && m_tready) begin
            boxes_seen++;
            if (expected_boxes.size() == 0) begin
                $display("%0t: unexpected box %h last %b", $time, m_tdata, m_tlast);
                errors++;
            end else begin
                e = expected_boxes.pop_front();
                if (m_tdata[31:0] !== e.x1 || m_tdata[63:32] !== e.y1 ||
                    m_tdata[95:64] !== e.x2 || m_tdata[127:96] !== e.y2 ||
                    m_tdata[131:128] !== e.slot || m_tlast !== e.last) begin
                    $display("%0t: box mismatch exp x1 %h y1 %h x2 %h y2 %h slot %0d last %b",
                             $time, e.x1, e.y1, e.x2, e.y2, e.slot, e.last);
                    $display("%0t:              act x1 %h y1 %h x2 %h y2 %h slot %0d last %b",
                             $time, m_tdata[31:0], m_tdata[63:32], m_tdata[95:64],
                             m_tdata[127:96], m_tdata[131:128], m_tlast);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted request or result
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (!s_tvalid && pending_reqs.size() == 0 && expected_boxes.size() == 0))
            stuck <= 0;
        else
            stuck <= stuck + 1;
        if (stuck > 20000) begin
            $display("%0t: no progress, %0d boxes outstanding", $time, expected_boxes.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(abg_pkg::cfg_reg_t idx, bit [26:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            abg_pkg::REG_ROUNDED: rounded_q = val[0];
            abg_pkg::REG_PIXEL:   pixel_q   = val[0];
            abg_pkg::REG_CLIP:    clip_q    = val[0];
            abg_pkg::REG_STRIDE:  stride_q  = 64'(val);
            abg_pkg::REG_IMG_H:   img_h_q   = 64'(val[15:0]);
            abg_pkg::REG_IMG_W:   img_w_q   = 64'(val[15:0]);
            abg_pkg::REG_COUNT:   count_q   = 64'(val[4:0]);
            default: ;
        endcase
    endtask

    task automatic setup(bit rnd, bit pix, bit clp, bit [26:0] str, bit [15:0] ih,
                         bit [15:0] iw, bit [4:0] cnt);
        write_reg(abg_pkg::REG_ROUNDED, 27'(rnd));
        write_reg(abg_pkg::REG_PIXEL, 27'(pix));
        write_reg(abg_pkg::REG_CLIP, 27'(clp));
        write_reg(abg_pkg::REG_STRIDE, str);
        write_reg(abg_pkg::REG_IMG_H, 27'(ih));
        write_reg(abg_pkg::REG_IMG_W, 27'(iw));
        write_reg(abg_pkg::REG_COUNT, 27'(cnt));
    endtask

    // Block drained: all requests taken, all boxes seen, plus a last load's latency
    task automatic drain();
        while (pending_reqs.size() != 0 || s_tvalid || expected_boxes.size() != 0)
            @(posedge aclk);
        repeat (600) @(posedge aclk);
    endtask

    function automatic void push_load(bit [3:0] slot, bit [26:0] s, bit [26:0] r);
        req_t q;
        q = '{abg_pkg::CMD_LOAD, slot, s, r, 12'($urandom), 12'($urandom)};
        pending_reqs.push_back(q);
    endfunction

    function automatic void push_emit(bit [11:0] gx, bit [11:0] gy);
        req_t q;
        q = '{abg_pkg::CMD_EMIT, 4'($urandom), 27'($urandom), 27'($urandom), gx, gy};
        pending_reqs.push_back(q);
    endfunction

    function automatic bit [26:0] rand_scale();
        case ($urandom_range(0, 3))
            0: return 27'($urandom_range(0, 1 << 26));
            1: return 27'($urandom_range(1 << 20, 1 << 24));
            default: return 27'($urandom_range(8 << 16, 512 << 16));
        endcase
    endfunction

    function automatic bit [26:0] rand_ratio();
        if ($urandom_range(0, 3) == 0) return 27'($urandom_range(1, 1 << 26));
        return 27'($urandom_range(1 << 14, 1 << 18));
    endfunction

    // Random part of one setting: fill the table, then mostly cells
    function automatic void random_phase(int n);
        for (int i = 0; i < 16; i++) push_load(4'(i), rand_scale(), rand_ratio());
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 15)
                push_load(4'($urandom_range(0, 15)), rand_scale(), rand_ratio());
            else
                push_emit(12'($urandom), 12'($urandom));
        end
    endfunction

    initial begin
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        rounded_q = 0; pixel_q = 0; clip_q = 0;
        stride_q = 1048576; img_h_q = 1; img_w_q = 1; count_q = 1;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: field extremes, both formulas, both placements, clipping
        setup(0, 0, 0, 27'(16 << 16), 600, 800, 16);
        push_load(0, 0, 1);
        push_load(1, 27'(1 << 26), 27'(1 << 26));
        push_load(2, 27'(1 << 26), 1);
        push_load(3, 0, 27'(1 << 26));
        for (int i = 4; i < 16; i++)
            push_load(4'(i), 27'((32 << 16) + i), 27'(65536 << (i % 3)));
        push_emit(0, 0);
        push_emit(12'hFFF, 12'hFFF);
        push_emit(12'hFFF, 0);
        push_emit(12'h555, 12'hAAA);
        drain();

        setup(1, 1, 1, 27'(16 << 16), 600, 800, 9);
        push_load(0, 27'(1 << 26), 27'(1 << 26));
        push_load(1, 0, 1);
        push_load(2, 27'(1 << 26), 1);
        push_load(3, 27'h7FFFFFF >> 1, 27'h3FFFFFF);
        for (int i = 4; i < 16; i++) push_load(4'(i), rand_scale(), 27'(32768 << (i % 3)));
        push_emit(0, 0);
        push_emit(12'hFFF, 12'hFFF);
        push_emit(12'h2, 12'h3);
        drain();

        // Random settings, extremes included
        setup(0, 1, 1, 27'(65536), 1, 1, 1);
        random_phase(25);
        drain();
        setup(1, 0, 1, 27'(1 << 26), 16'hFFFF, 16'hFFFF, 16);
        random_phase(30);
        drain();
        setup(0, 0, 1, 27'(8 << 16), 512, 512, 16);
        random_phase(45);
        drain();
        for (int p = 0; p < 3; p++) begin
            setup(1'($urandom), 1'($urandom), 1'($urandom),
                  27'($urandom_range(65536, 1 << 26)),
                  16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                  5'($urandom_range(1, 16)));
            random_phase(20);
            drain();
        end
        setup(1, 1, 0, 27'(32 << 16), 1024, 1024, 5'($urandom_range(1, 16)));
        random_phase(20);
        drain();

        if (expected_boxes.size() != 0) errors++;
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
`default_nettype wire
